// ===== rtl/smx_pkg.sv =====
package smx_pkg;

  localparam int unsigned DefStackDepth = 256;
  localparam int unsigned DefRamDepth   = 1024;
  localparam int unsigned DefDataWidth  = 32;
  localparam int unsigned DefLineWidth  = 16;

  localparam int unsigned ActW   = 5;
  localparam int unsigned RegSelW = 2;
  localparam int unsigned FieldW = 32;
  localparam int unsigned LineW  = 16;
  localparam int unsigned StatW  = 3;

  typedef enum logic [ActW-1:0] {
    ACT_PUSH    = 5'd0,
    ACT_TOREG   = 5'd1,
    ACT_TORAM   = 5'd2,
    ACT_POP     = 5'd3,
    ACT_FROMREG = 5'd4,
    ACT_FROMRAM = 5'd5,
    ACT_ADD     = 5'd6,
    ACT_MUL     = 5'd7,
    ACT_IN      = 5'd8,
    ACT_OUT     = 5'd9,
    ACT_NOP     = 5'd10,
    ACT_GOTO    = 5'd11,
    ACT_CMP     = 5'd12,
    ACT_CMPREG  = 5'd13,
    ACT_JE      = 5'd14,
    ACT_JL      = 5'd15,
    ACT_CALL    = 5'd16,
    ACT_RET     = 5'd17,
    ACT_END     = 5'd18,
    ACT_BAD     = 5'd19
  } action_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 3'd0,
    STAT_BAD_OP   = 3'd1,
    STAT_CANARY   = 3'd2,
    STAT_UNDER    = 3'd3,
    STAT_BAD_ADDR = 3'd4,
    STAT_OVER     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_FETCH,
    BS_EXEC,
    BS_PUSH2
  } back_state_e;

  // One decoded request as it sits in the queue between front and back.
  typedef struct packed {
    action_e                   act;
    logic [RegSelW-1:0]        reg_sel;
    logic [FieldW-1:0]         arg;
    logic [LineW-1:0]          line;
    logic [FieldW-1:0]         entered;
    logic [1:0]                need;
    logic [1:0]                room;
    logic                      addr_ok;
  } dec_t;

  typedef struct packed {
    logic [LineW-1:0]  next_line;
    logic              out_valid;
    logic [FieldW-1:0] out_value;
    status_e           status;
    logic              halted;
  } res_t;

endpackage

// ===== rtl/smx_if.sv =====
interface smx_in_if;
  import smx_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [ActW-1:0]           action;
  logic [RegSelW-1:0]        reg_select;
  logic signed [FieldW-1:0]  argument;
  logic [LineW-1:0]          current_line;
  logic signed [FieldW-1:0]  entered_value;

  modport source (output valid, action, reg_select, argument, current_line, entered_value,
                  input ready);
  modport sink (input valid, action, reg_select, argument, current_line, entered_value,
                output ready);
endinterface

interface smx_out_if;
  import smx_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [LineW-1:0]          next_line;
  logic                      out_valid;
  logic signed [FieldW-1:0]  out_value;
  logic [StatW-1:0]          status;
  logic                      halted;

  modport source (output valid, next_line, out_valid, out_value, status, halted,
                  input ready);
  modport sink (input valid, next_line, out_valid, out_value, status, halted,
                output ready);
endinterface

// ===== rtl/stack_machine_execute.sv =====
// Stack-machine executor: one instruction per request on in_i, one result per
// request on out_o, in order. A front stage decodes each request into a
// two-entry queue; the back stage executes it from a register-file stack
// memory with one write port and two registered read ports. Most instructions
// are read, then executed in the back stage; cmp and cmpreg add a push state for
// the argument, because their two stack pushes share the single write port. A
// finished result waits in an output register while the next request is
// already being read. After reset the back stage clears all RAM_DEPTH words of
// the data memory, one word per cycle, before it executes anything.
module stack_machine_execute #(
  parameter int unsigned STACK_DEPTH = smx_pkg::DefStackDepth,
  parameter int unsigned RAM_DEPTH   = smx_pkg::DefRamDepth,
  parameter int unsigned DATA_WIDTH  = smx_pkg::DefDataWidth,
  parameter int unsigned LINE_WIDTH  = smx_pkg::DefLineWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smx_in_if.sink    in_i,
  smx_out_if.source out_o
);
  import smx_pkg::*;

  dec_t dec;
  logic dec_valid, dec_ready;

  smx_front #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .dec_o       (dec),
    .dec_valid_o (dec_valid),
    .dec_ready_i (dec_ready)
  );

  smx_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .RAM_DEPTH   (RAM_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH),
    .LINE_WIDTH  (LINE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_i       (dec),
    .dec_valid_i (dec_valid),
    .dec_ready_o (dec_ready),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/smx_front.sv =====
module smx_front #(
  parameter int unsigned RAM_DEPTH = smx_pkg::DefRamDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  smx_in_if.sink        in_i,
  output smx_pkg::dec_t dec_o,
  output logic          dec_valid_o,
  input  logic          dec_ready_i
);
  import smx_pkg::*;

  dec_t       dec;
  dec_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  always_comb begin
    dec.reg_sel = in_i.reg_select;
    dec.arg     = in_i.argument;
    dec.line    = in_i.current_line;
    dec.entered = in_i.entered_value;
    dec.need    = 2'd0;
    dec.room    = 2'd0;
    dec.addr_ok = !in_i.argument[FieldW-1] &&
                  ($unsigned(in_i.argument) < FieldW'(RAM_DEPTH));
    if (in_i.action >= ACT_BAD) begin
      dec.act = ACT_BAD;
    end else begin
      dec.act = action_e'(in_i.action);
    end
    case (dec.act)
      ACT_POP, ACT_TOREG, ACT_TORAM, ACT_OUT, ACT_CMP, ACT_RET: dec.need = 2'd1;
      ACT_ADD, ACT_MUL, ACT_JE, ACT_JL:                         dec.need = 2'd2;
      default:                                                  dec.need = 2'd0;
    endcase
    case (dec.act)
      ACT_PUSH, ACT_FROMREG, ACT_FROMRAM, ACT_IN, ACT_CALL: dec.room = 2'd1;
      ACT_CMP, ACT_CMPREG:                                  dec.room = 2'd2;
      default:                                              dec.room = 2'd0;
    endcase
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign dec_valid_o = (cnt_q != 2'd0);
  assign pop         = dec_valid_o && dec_ready_i;
  assign dec_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/smx_back.sv =====
module smx_back #(
  parameter int unsigned STACK_DEPTH = smx_pkg::DefStackDepth,
  parameter int unsigned RAM_DEPTH   = smx_pkg::DefRamDepth,
  parameter int unsigned DATA_WIDTH  = smx_pkg::DefDataWidth,
  parameter int unsigned LINE_WIDTH  = smx_pkg::DefLineWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  smx_pkg::dec_t dec_i,
  input  logic          dec_valid_i,
  output logic          dec_ready_o,
  smx_out_if.source     out_o
);
  import smx_pkg::*;

  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(RAM_DEPTH);
  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned LW = LINE_WIDTH;

  back_state_e     state_q, state_d;
  dec_t            cur_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [DW-1:0]   reg_q [4];
  logic [DW-1:0]   stk_mem [STACK_DEPTH];
  logic [DW-1:0]   ram_mem [RAM_DEPTH];
  logic [DW-1:0]   t0_q, t1_q, ram_rd_q;
  res_t            res_q, res_d;
  logic            res_vld_q;

  logic            fetch, commit, reg_we;
  logic            stk_we, ram_we;
  logic [SW-1:0]   stk_wa;
  logic [DW-1:0]   stk_wd, ram_wd, reg_wd;
  logic [AW-1:0]   ram_wa;
  logic [CW-1:0]   cm1, cm2;
  status_e         stat;
  logic [DW-1:0]   arg_d, sum, prod, reg_rd;
  logic [DW:0]     ret_sum;
  logic [LW-1:0]   next_l, target;

  assign cm1     = cnt_q - CW'(1);
  assign cm2     = cnt_q - CW'(2);
  assign arg_d   = DW'($signed(cur_q.arg));
  assign sum     = t0_q + t1_q;
  assign prod    = t0_q * t1_q;
  assign reg_rd  = reg_q[cur_q.reg_sel];
  assign ret_sum = {1'b0, t0_q} + (DW + 1)'(1);
  assign target  = cur_q.arg[LW-1:0];

  // Error priority: opcode, then address, then too few entries, then no room.
  always_comb begin
    if (cur_q.act == ACT_BAD) begin
      stat = STAT_BAD_OP;
    end else if ((cur_q.act == ACT_TORAM || cur_q.act == ACT_FROMRAM) && !cur_q.addr_ok) begin
      stat = STAT_BAD_ADDR;
    end else if (cnt_q < CW'(cur_q.need)) begin
      stat = STAT_UNDER;
    end else if ((CW'(STACK_DEPTH) - cnt_q) < CW'(cur_q.room)) begin
      stat = STAT_OVER;
    end else begin
      stat = STAT_OK;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    dec_ready_o = 1'b0;
    fetch       = 1'b0;
    commit      = 1'b0;
    stk_we      = 1'b0;
    stk_wa      = cnt_q[SW-1:0];
    stk_wd      = '0;
    ram_we      = 1'b0;
    ram_wa      = cur_q.arg[AW-1:0];
    ram_wd      = t0_q;
    reg_we      = 1'b0;
    reg_wd      = t0_q;
    next_l      = LW'(cur_q.line) + LW'(1);
    res_d       = res_q;
    case (state_q)
      BS_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_q;
        ram_wd = '0;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(RAM_DEPTH - 1)) begin
          state_d = BS_FETCH;
        end
      end
      BS_FETCH: begin
        dec_ready_o = 1'b1;
        if (dec_valid_i) begin
          fetch   = 1'b1;
          state_d = BS_EXEC;
        end
      end
      BS_EXEC: begin
        if (!res_vld_q || out_o.ready) begin
          commit  = 1'b1;
          state_d = BS_FETCH;
          res_d.out_valid = 1'b0;
          res_d.out_value = '0;
          res_d.status    = stat;
          res_d.halted    = (stat != STAT_OK) || (cur_q.act == ACT_END);
          if (stat == STAT_OK) begin
            case (cur_q.act)
              ACT_PUSH: begin
                stk_we = 1'b1; stk_wd = arg_d; cnt_d = cnt_q + CW'(1);
              end
              ACT_TOREG: reg_we = 1'b1;
              ACT_TORAM: ram_we = 1'b1;
              ACT_POP:   cnt_d = cm1;
              ACT_FROMREG: begin
                stk_we = 1'b1; stk_wd = reg_rd; cnt_d = cnt_q + CW'(1);
              end
              ACT_FROMRAM: begin
                stk_we = 1'b1; stk_wd = ram_rd_q; cnt_d = cnt_q + CW'(1);
              end
              ACT_ADD, ACT_MUL: begin
                stk_we = 1'b1;
                stk_wa = cm2[SW-1:0];
                stk_wd = (cur_q.act == ACT_ADD) ? sum : prod;
                cnt_d  = cm1;
              end
              ACT_IN: begin
                stk_we = 1'b1; stk_wd = DW'($signed(cur_q.entered));
                cnt_d  = cnt_q + CW'(1);
              end
              ACT_OUT: begin
                res_d.out_valid = 1'b1;
                res_d.out_value = FieldW'($signed(t0_q));
              end
              ACT_GOTO: next_l = target;
              ACT_CMP, ACT_CMPREG: begin
                // The second push (the argument) follows in its own cycle.
                stk_we  = 1'b1;
                stk_wd  = (cur_q.act == ACT_CMP) ? t0_q : reg_rd;
                cnt_d   = cnt_q + CW'(1);
                state_d = BS_PUSH2;
              end
              ACT_JE: begin
                cnt_d = cm2;
                if (t1_q == t0_q) next_l = target;
              end
              ACT_JL: begin
                cnt_d = cm2;
                if ($signed(t1_q) < $signed(t0_q)) next_l = target;
              end
              ACT_CALL: begin
                stk_we = 1'b1; stk_wd = DW'(cur_q.line);
                cnt_d  = cnt_q + CW'(1);
                next_l = target;
              end
              ACT_RET: begin
                cnt_d  = cm1;
                next_l = LW'(ret_sum);
              end
              ACT_END: cnt_d = '0;
              default: ;
            endcase
          end
          res_d.next_line = LineW'(next_l);
        end
      end
      BS_PUSH2: begin
        stk_we  = 1'b1;
        stk_wd  = arg_d;
        cnt_d   = cnt_q + CW'(1);
        state_d = BS_FETCH;
      end
      default: state_d = BS_FETCH;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (fetch) begin
      t0_q <= stk_mem[cm1[SW-1:0]];
      t1_q <= stk_mem[cm2[SW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_wa] <= ram_wd;
    end
    if (fetch) begin
      ram_rd_q <= ram_mem[dec_i.arg[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      cur_q <= dec_i;
    end
    if (commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_CLEAR;
      cnt_q     <= '0;
      clr_q     <= '0;
      res_vld_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        reg_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      if (commit) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
      if (reg_we) begin
        reg_q[cur_q.reg_sel] <= reg_wd;
      end
    end
  end

  assign out_o.valid     = res_vld_q;
  assign out_o.next_line = res_q.next_line;
  assign out_o.out_valid = res_q.out_valid;
  assign out_o.out_value = res_q.out_value;
  assign out_o.status    = res_q.status;
  assign out_o.halted    = res_q.halted;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_err_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && stat != STAT_OK |=> cnt_q == $past(cnt_q))
    else $error("failed instruction changed the stack");

  a_no_fetch_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BS_CLEAR |-> !dec_ready_o && !commit)
    else $error("request taken during memory clear");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !out_o.ready |-> !commit)
    else $error("held result overwritten");

endmodule

// ===== tb/sv/smx_checker.sv =====
`timescale 1ns / 1ps

module smx_checker
  import smx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  smx_in_if    in_w,
  smx_out_if   out_w,
  output int   pending_o,
  output int   fail_count_o
);

  localparam int unsigned StackDepth = DefStackDepth;
  localparam int unsigned RamDepth   = DefRamDepth;

  logic [FieldW-1:0] stack_mem [StackDepth];
  int unsigned       stack_depth;
  logic [FieldW-1:0] gp_regs [4];
  logic [FieldW-1:0] data_ram [RamDepth];
  res_t              result_q [$];
  int                errors;

  assign fail_count_o = errors;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void push_word(input logic [FieldW-1:0] v);
    stack_mem[stack_depth] = v;
    stack_depth++;
  endfunction

  function automatic res_t run_instr(input logic [ActW-1:0] act, input logic [1:0] rs,
                                     input logic [FieldW-1:0] arg,
                                     input logic [LineW-1:0] line,
                                     input logic [FieldW-1:0] ent);
    res_t r;
    int unsigned need;
    int unsigned room;
    logic addr_ok;
    logic [FieldW-1:0] a;
    logic [FieldW-1:0] b;
    r = '0;
    r.next_line = line + 1'b1;
    r.status = STAT_OK;
    need = 0;
    room = 0;
    addr_ok = !arg[FieldW-1] && (arg < RamDepth);
    case (act)
      ACT_POP, ACT_TOREG, ACT_TORAM, ACT_OUT, ACT_CMP, ACT_RET: need = 1;
      ACT_ADD, ACT_MUL, ACT_JE, ACT_JL: need = 2;
      default: need = 0;
    endcase
    case (act)
      ACT_PUSH, ACT_FROMREG, ACT_FROMRAM, ACT_IN, ACT_CALL: room = 1;
      ACT_CMP, ACT_CMPREG: room = 2;
      default: room = 0;
    endcase
    if (act >= ACT_BAD) begin
      r.status = STAT_BAD_OP;
    end else if ((act == ACT_TORAM || act == ACT_FROMRAM) && !addr_ok) begin
      r.status = STAT_BAD_ADDR;
    end else if (stack_depth < need) begin
      r.status = STAT_UNDER;
    end else if (StackDepth - stack_depth < room) begin
      r.status = STAT_OVER;
    end else begin
      case (act)
        ACT_PUSH:    push_word(arg);
        ACT_TOREG:   gp_regs[rs] = stack_mem[stack_depth-1];
        ACT_TORAM:   data_ram[arg] = stack_mem[stack_depth-1];
        ACT_POP:     stack_depth--;
        ACT_FROMREG: push_word(gp_regs[rs]);
        ACT_FROMRAM: push_word(data_ram[arg]);
        ACT_ADD, ACT_MUL: begin
          a = stack_mem[stack_depth-1];
          b = stack_mem[stack_depth-2];
          stack_depth -= 2;
          push_word(act == ACT_ADD ? a + b : a * b);
        end
        ACT_IN:      push_word(ent);
        ACT_OUT: begin
          r.out_valid = 1'b1;
          r.out_value = stack_mem[stack_depth-1];
        end
        ACT_GOTO:    r.next_line = arg[LineW-1:0];
        ACT_CMP: begin
          a = stack_mem[stack_depth-1];
          push_word(a);
          push_word(arg);
        end
        ACT_CMPREG: begin
          push_word(gp_regs[rs]);
          push_word(arg);
        end
        ACT_JE, ACT_JL: begin
          b = stack_mem[stack_depth-1];
          a = stack_mem[stack_depth-2];
          stack_depth -= 2;
          if (act == ACT_JE ? (a == b) : ($signed(a) < $signed(b)))
            r.next_line = arg[LineW-1:0];
        end
        ACT_CALL: begin
          push_word({{(FieldW-LineW){1'b0}}, line});
          r.next_line = arg[LineW-1:0];
        end
        ACT_RET: begin
          a = stack_mem[stack_depth-1];
          stack_depth--;
          r.next_line = a[LineW-1:0] + 1'b1;
        end
        ACT_END: begin
          stack_depth = 0;
          r.halted = 1'b1;
        end
        default: ;
      endcase
    end
    if (r.status != STAT_OK) r.halted = 1'b1;
    return r;
  endfunction

  initial begin
    stack_depth = 0;
    errors = 0;
    foreach (gp_regs[i]) gp_regs[i] = '0;
    foreach (data_ram[i]) data_ram[i] = '0;
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_w.valid && out_w.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", out_w.next_line, 0);
        end else begin
          want = result_q.pop_front();
          if (out_w.next_line !== want.next_line)
            report_mismatch("next_line", out_w.next_line, want.next_line);
          if (out_w.out_valid !== want.out_valid)
            report_mismatch("out_valid", out_w.out_valid, want.out_valid);
          if (out_w.out_value !== want.out_value)
            report_mismatch("out_value", out_w.out_value, want.out_value);
          if (out_w.status !== want.status)
            report_mismatch("status", out_w.status, want.status);
          if (out_w.halted !== want.halted)
            report_mismatch("halted", out_w.halted, want.halted);
        end
      end
      if (in_w.valid && in_w.ready)
        result_q.push_back(run_instr(in_w.action, in_w.reg_select, in_w.argument,
                                     in_w.current_line, in_w.entered_value));
    end
    pending_o <= result_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import smx_pkg::*;

  localparam logic [FieldW-1:0] RamDepth = DefRamDepth;

  logic clk_i;
  logic rst_ni;
  int   pending;
  int   fail_count;
  bit   no_stalls;

  smx_in_if  in_w ();
  smx_out_if out_w ();

  stack_machine_execute i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  smx_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_w),
    .out_w        (out_w),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_stalls || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side back-pressure.
  initial begin
    int stall;
    out_w.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        out_w.ready <= 1'b0;
        stall--;
      end else begin
        out_w.ready <= 1'b1;
        stall = gap_len();
      end
    end
  end

  task automatic send_request(input logic [ActW-1:0] act, input logic [1:0] rs,
                              input logic [FieldW-1:0] arg, input logic [LineW-1:0] line,
                              input logic [FieldW-1:0] ent);
    int gap;
    in_w.valid         <= 1'b1;
    in_w.action        <= act;
    in_w.reg_select    <= rs;
    in_w.argument      <= arg;
    in_w.current_line  <= line;
    in_w.entered_value <= ent;
    do @(posedge clk_i); while (!in_w.ready);
    gap = gap_len();
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [FieldW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 9);
      3: return -$urandom_range(1, 9);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FieldW-1:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return RamDepth;
      1: return -1;
      2: return $urandom;
      3: return RamDepth - 1;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  // Draws an action; fill_mode favors pushes so the stack reaches its limit.
  function automatic logic [ActW-1:0] pick_action(input bit fill_mode);
    int r;
    r = $urandom_range(0, 99);
    if (fill_mode && r < 75) return ($urandom_range(0, 1) ? ACT_PUSH : ACT_CMP);
    if (r < 2) return ActW'($urandom_range(ACT_BAD, 31));
    if (r < 3) return ACT_END;
    return ActW'($urandom_range(ACT_PUSH, ACT_RET));
  endfunction

  initial begin
    logic [ActW-1:0]   act;
    logic [FieldW-1:0] arg;
    logic [LineW-1:0]  line;
    bit                fill_mode;
    rst_ni = 1'b0;
    no_stalls = 1'b0;
    in_w.valid = 1'b0;
    in_w.action = ACT_NOP;
    in_w.reg_select = '0;
    in_w.argument = '0;
    in_w.current_line = '0;
    in_w.entered_value = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(ACT_POP, 0, 0, 0, 0);
    send_request(ACT_PUSH, 0, 32'h7fff_ffff, 16'd1, 0);
    send_request(ACT_PUSH, 0, 32'h8000_0000, 16'd2, 0);
    send_request(ACT_ADD, 0, 0, 16'd3, 0);
    send_request(ACT_IN, 0, 0, 16'd4, 32'hffff_ffff);
    send_request(ACT_MUL, 0, 0, 16'd5, 0);
    send_request(ACT_OUT, 0, 0, 16'd6, 0);
    send_request(ACT_TOREG, 3, 0, 16'd7, 0);
    send_request(ACT_FROMREG, 3, 0, 16'd8, 0);
    send_request(ACT_TORAM, 0, RamDepth - 1, 16'd9, 0);
    send_request(ACT_TORAM, 0, RamDepth, 16'd10, 0);
    send_request(ACT_FROMRAM, 0, 32'hffff_ffff, 16'd11, 0);
    send_request(ACT_FROMRAM, 0, RamDepth - 1, 16'd12, 0);
    send_request(ACT_CMP, 0, 32'h8000_0000, 16'd13, 0);
    send_request(ACT_JE, 0, 32'hffff_0005, 16'd14, 0);
    send_request(ACT_CMPREG, 2, 32'h7fff_ffff, 16'd15, 0);
    send_request(ACT_JL, 0, 32'h0000_1234, 16'd16, 0);
    send_request(ACT_CALL, 0, 32'h0000_ffff, 16'hffff, 0);
    send_request(ACT_RET, 0, 0, 16'h0, 0);
    send_request(ACT_GOTO, 0, 32'habcd_0000, 16'd20, 0);
    send_request(ACT_NOP, 0, 0, 16'hffff, 0);
    send_request(ACT_END, 0, 0, 16'd22, 0);
    send_request(ACT_JE, 0, 0, 16'd23, 0);
    send_request(ACT_BAD, 0, 0, 16'd24, 0);
    send_request(5'd31, 0, 0, 16'd25, 0);

    for (int n = 0; n < 1600; n++) begin
      fill_mode = (n % 400) >= 200 && (n % 400) < 330;
      if (n % 300 == 100) no_stalls = ~no_stalls;
      // Let the block drain completely once, mid-run.
      if (n == 800) begin
        in_w.valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      act = pick_action(fill_mode);
      line = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom);
      if (act == ACT_TORAM || act == ACT_FROMRAM) arg = pick_addr();
      else arg = pick_value();
      send_request(act, 2'($urandom), arg, line, pick_value());
    end
    in_w.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[stack_machine_execute] OK");
    end else begin
      $display("[stack_machine_execute] ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[stack_machine_execute] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/smx_pkg.sv
rtl/smx_if.sv
rtl/smx_front.sv
rtl/smx_back.sv
rtl/stack_machine_execute.sv
tb/sv/smx_checker.sv
tb/sv/tb.sv
